// ----- src/sbem_pkg.sv -----
// Package for the segmented big-endian memory: sizes, region selects,
// status and size codes, decode structures and the control state type.
// No dependencies.
package sbem_pkg;

    // Bytes in each of the three stores.
    localparam int REGION_BYTES = 65536;

    // Each store is held as 32-bit words; a partial last word is rounded up.
    localparam int WORDS     = (REGION_BYTES + 3) / 4;
    localparam int WORD_AW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int MEM_DEPTH = 3 * WORDS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Region selects, address bits 31:20.
    localparam logic [11:0] SEL_PROGRAM = 12'h004;
    localparam logic [11:0] SEL_DATA    = 12'h100;
    localparam logic [11:0] SEL_STACK   = 12'h7FF;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_BAD  = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
    localparam logic [1:0] STATUS_BADSIZE  = 2'd2;

    // What the output side needs to know about an item.
    typedef struct packed {
        logic [1:0] status;
        logic       wr;
        logic [1:0] size;
        logic [1:0] lane;
    } meta_t;

    // Decoded item: result info plus the memory request.
    typedef struct packed {
        meta_t              meta;
        logic               mem_en;
        logic [MEM_AW-1:0]  mem_addr;
        logic [3:0]         be;
        logic [31:0]        wdata;
    } dec_t;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } ctrl_state_t;

endpackage

// ----- src/sbem_ram.sv -----
// Generic single-port word RAM with byte enables and registered read data.
// No dependencies.
module sbem_ram #(
    parameter int DEPTH = 4,
    parameter int AW    = 2
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [3:0]    be,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem_array [0:DEPTH-1];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (be[i])
                    begin
                        mem_array[addr][8*i +: 8] <= wdata[8*i +: 8];
                    end
                end
            end
            else
            begin
                rdata_reg <= mem_array[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sbem_dec.sv -----
// Item decode: size check, region select, alignment, bounds check, word
// address, byte enables and lane-replicated write data. Uses sbem_pkg.
module sbem_dec (
    input  logic          op,
    input  logic [31:0]   address,
    input  logic [1:0]    access_size,
    input  logic [31:0]   write_data,
    output sbem_pkg::dec_t dec
);
    import sbem_pkg::*;

    logic [11:0]       sel;
    logic [19:0]       off_al;
    logic [2:0]        nbytes;
    logic              mapped;
    logic [MEM_AW-1:0] base;
    logic [20:0]       end_sum;
    logic              beyond;
    logic [1:0]        status;
    logic [1:0]        lane;
    logic [3:0]        lane_be;
    logic [31:0]       lane_wdata;

    assign sel = address[31:20];

    // Force alignment and find the access length.
    always_comb
    begin
        unique case (access_size)
            SIZE_BYTE:
            begin
                off_al = address[19:0];
                nbytes = 3'd1;
            end
            SIZE_HALF:
            begin
                off_al = {address[19:1], 1'b0};
                nbytes = 3'd2;
            end
            SIZE_WORD:
            begin
                off_al = {address[19:2], 2'b00};
                nbytes = 3'd4;
            end
            SIZE_BAD:
            begin
                off_al = address[19:0];
                nbytes = 3'd1;
            end
        endcase
    end

    always_comb
    begin
        unique case (sel)
            SEL_PROGRAM:
            begin
                mapped = 1'b1;
                base   = MEM_AW'(0);
            end
            SEL_DATA:
            begin
                mapped = 1'b1;
                base   = MEM_AW'(WORDS);
            end
            SEL_STACK:
            begin
                mapped = 1'b1;
                base   = MEM_AW'(2 * WORDS);
            end
            default:
            begin
                mapped = 1'b0;
                base   = MEM_AW'(0);
            end
        endcase
    end

    assign end_sum = {1'b0, off_al} + 21'(nbytes);
    assign beyond  = end_sum > 21'(REGION_BYTES);
    assign lane    = off_al[1:0];

    // Bad size wins over the region check.
    always_comb
    begin
        priority if (access_size == SIZE_BAD)
        begin
            status = STATUS_BADSIZE;
        end
        else if (!mapped || beyond)
        begin
            status = STATUS_UNMAPPED;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    // Big-endian lanes: offset 0 of a word sits in bits 31:24.
    always_comb
    begin
        unique case (access_size)
            SIZE_BYTE:
            begin
                lane_be    = 4'b1000 >> lane;
                lane_wdata = {4{write_data[7:0]}};
            end
            SIZE_HALF:
            begin
                lane_be    = lane[1] ? 4'b0011 : 4'b1100;
                lane_wdata = {2{write_data[15:0]}};
            end
            SIZE_WORD:
            begin
                lane_be    = 4'b1111;
                lane_wdata = write_data;
            end
            SIZE_BAD:
            begin
                lane_be    = 4'b0000;
                lane_wdata = write_data;
            end
        endcase
    end

    assign dec.meta.status = status;
    assign dec.meta.wr     = (op == OP_WRITE);
    assign dec.meta.size   = access_size;
    assign dec.meta.lane   = lane;
    assign dec.mem_en      = (status == STATUS_OK);
    assign dec.mem_addr    = base + MEM_AW'(off_al[2 +: WORD_AW]);
    assign dec.be          = lane_be;
    assign dec.wdata       = lane_wdata;

endmodule

// ----- src/segmented_big_endian_memory.sv -----
// Top level of the segmented big-endian memory: clearing sequencer, item
// and result registers, result formatting. Uses sbem_pkg, sbem_dec, sbem_ram.
//
// One memory access per item, one result per item. Three byte stores
// (program at region 0x004, data at 0x100, stack at 0x7FF, selected by
// address bits 31:20) share one word-wide RAM of 3*REGION_BYTES/4 words with
// byte enables; bytes are big-endian within a word. An item is taken in
// every cycle unless in_stall is high (clearing, or a result waiting under
// out_stall): the RAM is read or written at the accepting edge, and the
// result appears on the next cycle, held in a result register until taken.
// Out of reset the block runs a clearing pass that writes zero to every
// RAM word, one word a cycle, during which in_stall stays high. Errors
// never halt the block: size 3 gives status 2, an unmapped region or an
// access running past the end of a store gives status 1, both with
// read_data 0 and no store change. A completed write returns read_data 1.
module segmented_big_endian_memory (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [31:0] address,
    input  logic [1:0]  access_size,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic [1:0]  status
);
    import sbem_pkg::*;

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [MEM_AW-1:0] clr_cnt_next;
    logic              clearing;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    meta_t             s1_meta_reg;

    dec_t              dec;
    logic              in_fire;
    logic              out_fire;
    logic              ram_en;
    logic              ram_we;
    logic [3:0]        ram_be;
    logic [MEM_AW-1:0] ram_addr;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_rdata;
    logic [31:0]       rd_value;
    logic [4:0]        byte_shift;

    sbem_dec u_dec (
        .op          (op),
        .address     (address),
        .access_size (access_size),
        .write_data  (write_data),
        .dec         (dec)
    );

    // Next state of the clearing sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing     = 1'b1;
                clr_cnt_next = clr_cnt_reg + MEM_AW'(1);
            end
            ST_RUN:
            begin
                clearing     = 1'b0;
                clr_cnt_next = clr_cnt_reg;
            end
        endcase
    end

    // Hold the input while clearing or while a result still waits.
    assign in_stall = clearing || (s1_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = s1_valid_reg && !out_stall;

    // The clearing pass owns the RAM port; otherwise an accepted item with
    // a good status reads or writes its word.
    assign ram_en    = clearing || (in_fire && dec.mem_en);
    assign ram_we    = clearing || dec.meta.wr;
    assign ram_be    = clearing ? 4'b1111 : dec.be;
    assign ram_addr  = clearing ? clr_cnt_reg : dec.mem_addr;
    assign ram_wdata = clearing ? 32'd0 : dec.wdata;

    sbem_ram #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .be    (ram_be),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Result info travels beside the RAM read; advance only on accept.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_meta_reg <= dec.meta;
        end
    end

    // Pick the addressed bytes out of the big-endian word.
    assign byte_shift = {~s1_meta_reg.lane, 3'b000};

    always_comb
    begin
        unique case (s1_meta_reg.size)
            SIZE_BYTE:
            begin
                rd_value = {24'd0, 8'(ram_rdata >> byte_shift)};
            end
            SIZE_HALF:
            begin
                rd_value = s1_meta_reg.lane[1] ? {16'd0, ram_rdata[15:0]}
                                               : {16'd0, ram_rdata[31:16]};
            end
            SIZE_WORD:
            begin
                rd_value = ram_rdata;
            end
            SIZE_BAD:
            begin
                rd_value = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        priority if (s1_meta_reg.status != STATUS_OK)
        begin
            read_data = 32'd0;
        end
        else if (s1_meta_reg.wr)
        begin
            read_data = 32'd1;
        end
        else
        begin
            read_data = rd_value;
        end
    end

    assign out_valid = s1_valid_reg;
    assign status    = s1_meta_reg.status;

`ifndef ASSERT_OFF
    // No item may slip in while the clearing pass owns the RAM.
    a_no_accept_in_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_fire
    ) else $error("item accepted during clearing pass");

    // Every accepted item shows up as a result on the next cycle.
    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid
    ) else $error("accepted item produced no result");

    // Errors report zero data.
    a_error_zero_data: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (read_data == 32'd0)
    ) else $error("error result with nonzero data");

    // A good write always reports one.
    a_write_ack: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_OK) && s1_meta_reg.wr) |-> (read_data == 32'd1)
    ) else $error("completed write did not return one");
`endif

endmodule

// ----- bench/segmented_big_endian_memory_checker.sv -----
`timescale 1ns / 1ps
// Checker for the segmented big-endian memory: watches both channels, keeps
// its own copy of the three byte stores and compares every result in order.
// Depends on sbem_pkg.
module segmented_big_endian_memory_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [31:0] address,
    input  logic [1:0]  access_size,
    input  logic [31:0] write_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] read_data,
    input  logic [1:0]  status,
    output int          mismatch_count,
    output int          pending_results,
    output int          checked_results
);
    import sbem_pkg::*;

    typedef enum int {
        STORE_PROGRAM = 0,
        STORE_DATA    = 1,
        STORE_STACK   = 2,
        STORE_NONE    = 3
    } store_sel_t;

    localparam int STORE_COUNT = 3;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
    } access_result_t;

    bit [7:0]       shadow_store [STORE_COUNT][REGION_BYTES];
    access_result_t expected_results [$];

    // Apply one access to the shadow stores and return what the block owes.
    function automatic access_result_t apply_access(input logic wr, input logic [31:0] addr,
                                                    input logic [1:0] size,
                                                    input logic [31:0] wdata);
        access_result_t res;
        store_sel_t     which;
        int unsigned    nbytes;
        int unsigned    offset;
        int unsigned    i;
        logic [31:0]    value;

        res.read_data = '0;
        res.status    = STATUS_OK;
        // Size check comes before the region decode.
        if (size == SIZE_BAD)
        begin
            res.status = STATUS_BADSIZE;
            return res;
        end
        case (addr[31:20])
            SEL_PROGRAM: which = STORE_PROGRAM;
            SEL_DATA:    which = STORE_DATA;
            SEL_STACK:   which = STORE_STACK;
            default:     which = STORE_NONE;
        endcase
        if (which == STORE_NONE)
        begin
            res.status = STATUS_UNMAPPED;
            return res;
        end
        nbytes = 1 << size;
        offset = addr[19:0] & ~(nbytes - 1);
        if (offset + nbytes > REGION_BYTES)
        begin
            res.status = STATUS_UNMAPPED;
            return res;
        end
        value = '0;
        for (i = 0; i < nbytes; i++)
        begin
            if (wr == OP_WRITE)
                shadow_store[which][offset + i] = 8'(wdata >> (8 * (nbytes - 1 - i)));
            else
                value = {value[23:0], shadow_store[which][offset + i]};
        end
        res.read_data = (wr == OP_WRITE) ? 32'd1 : value;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t want;

        if (!rst_n)
        begin
            foreach (shadow_store[s, b])
                shadow_store[s][b] = 8'h00;
            expected_results.delete();
            mismatch_count  = 0;
            pending_results = 0;
            checked_results = 0;
        end
        else
        begin
            // Check the outgoing item first: a result never leaves in the
            // cycle its access is taken.
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: read_data %h status %0d",
                           read_data, status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked_results++;
                    if (read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, actual %h", want.read_data, read_data);
                        mismatch_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_access(op, address, access_size, write_data));
            pending_results = expected_results.size();
        end
    end

endmodule

// ----- bench/segmented_big_endian_memory_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the segmented big-endian memory: clock, reset, stimulus
// and verdict. Depends on sbem_pkg, the block and the checker module.
module segmented_big_endian_memory_tb;
    import sbem_pkg::*;

    // Random items per idling mix.
    localparam int RANDOM_PER_PHASE = 560;
    // Items offered while the output is held off.
    localparam int BURST_ITEMS      = 40;
    // Length of the long output hold-off, in cycles.
    localparam int HOLD_OFF_CYCLES  = 80;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [31:0] address;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] read_data;
    logic [1:0]  status;

    int mismatch_count;
    int pending_results;
    int checked_results;

    int items_sent;
    int sender_idle_pct;
    int receiver_stall_pct;
    // Bumped by the stimulus to ask the receiver for one long hold-off.
    int hold_off_requests;

    segmented_big_endian_memory dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .address     (address),
        .access_size (access_size),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .status      (status)
    );

    segmented_big_endian_memory_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .address         (address),
        .access_size     (access_size),
        .write_data      (write_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .status          (status),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .checked_results (checked_results)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one item: idle at random first, then hold the payload until the
    // block takes it. Return at the falling edge after acceptance with valid
    // still high, so the caller either drives the next item or drops valid.
    task automatic send_access(input logic wr, input logic [31:0] addr,
                               input logic [1:0] size, input logic [31:0] wdata);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        op          <= wr;
        address     <= addr;
        access_size <= size;
        write_data  <= wdata;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Random access. Most items land in small windows at the start and the
    // end of the three stores so reads see earlier writes; the rest spread
    // over a whole store, run past its end, or hit unmapped space.
    task automatic send_random_access();
        logic [11:0] region;
        logic [19:0] offset;
        logic [31:0] addr;
        logic [1:0]  size;
        int          pick;

        pick = $urandom_range(99, 0);
        if (pick < 85) begin
            case ($urandom_range(2, 0))
                0:       region = SEL_PROGRAM;
                1:       region = SEL_DATA;
                default: region = SEL_STACK;
            endcase
            pick = $urandom_range(99, 0);
            if (pick < 45)
                offset = 20'($urandom_range(63, 0));
            else if (pick < 65)
                offset = 20'(REGION_BYTES - 64 + $urandom_range(63, 0));
            else if (pick < 80)
                offset = 20'($urandom_range(REGION_BYTES - 1, 0));
            else
                offset = 20'($urandom_range(20'hFFFFF, REGION_BYTES - 4));
            addr = {region, offset};
        end
        else begin
            addr = $urandom();
        end
        size = ($urandom_range(99, 0) < 6) ? SIZE_BAD : 2'($urandom_range(2, 0));
        send_access(($urandom_range(1, 0) != 0) ? OP_WRITE : OP_READ, addr, size, $urandom());
    endtask

    // Receiver: stall at random, or hold off for a long stretch on request.
    initial
    begin
        int hold_left;
        int served;

        hold_left = 0;
        served    = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (served != hold_off_requests) begin
                served    = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else begin
                out_stall <= ($urandom_range(99, 0) < receiver_stall_pct);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        op                 = OP_READ;
        address            = '0;
        access_size        = SIZE_BYTE;
        write_data         = '0;
        items_sent         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_requests  = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed corners. The first item waits out the clearing pass.
        send_access(OP_READ,  32'h0040_0000, SIZE_WORD, 32'h0);          // cleared store
        send_access(OP_WRITE, 32'h1000_0000, SIZE_WORD, 32'h1122_3344);
        send_access(OP_READ,  32'h1000_0000, SIZE_BYTE, 32'h0);          // top byte first
        send_access(OP_READ,  32'h1000_0003, SIZE_BYTE, 32'h0);
        send_access(OP_READ,  32'h1000_0003, SIZE_HALF, 32'h0);          // aligned down
        send_access(OP_READ,  32'h1000_0003, SIZE_WORD, 32'h0);
        send_access(OP_WRITE, 32'h7FF0_FFFF, SIZE_HALF, 32'hFFFF_ABCD);  // last half of stack
        send_access(OP_READ,  32'h7FF0_FFFC, SIZE_WORD, 32'h0);
        send_access(OP_WRITE, 32'h0040_FFFF, SIZE_BYTE, 32'hFFFF_FFFF);  // last byte of program
        send_access(OP_READ,  32'h0040_FFFF, SIZE_BYTE, 32'h0);
        send_access(OP_WRITE, 32'h0040_FFFE, SIZE_WORD, 32'hDEAD_BEEF);  // last word
        send_access(OP_READ,  32'h0040_FFFD, SIZE_HALF, 32'h0);
        send_access(OP_READ,  32'h0041_0000, SIZE_BYTE, 32'h0);          // past end of store
        send_access(OP_WRITE, 32'h7FFF_FFFF, SIZE_WORD, 32'hFFFF_FFFF);  // past end, top address
        send_access(OP_WRITE, 32'h1001_0000, SIZE_HALF, 32'h5555_5555);
        send_access(OP_READ,  32'h0000_0000, SIZE_WORD, 32'h0);          // unmapped
        send_access(OP_WRITE, 32'hFFFF_FFFF, SIZE_BYTE, 32'hFFFF_FFFF);
        send_access(OP_READ,  32'h0050_0000, SIZE_HALF, 32'h0);
        send_access(OP_READ,  32'h0000_0000, SIZE_BAD,  32'h0);          // bad size beats unmapped
        send_access(OP_WRITE, 32'h1000_0000, SIZE_BAD,  32'hAAAA_AAAA);  // bad size, no store change
        send_access(OP_READ,  32'h1000_0000, SIZE_WORD, 32'h0);
        send_access(OP_WRITE, 32'h0040_0000, SIZE_WORD, 32'h0000_0000);
        send_access(OP_READ,  32'h0040_0002, SIZE_HALF, 32'h0);

        // Mostly busy sender, busy receiver.
        sender_idle_pct     = 16;
        receiver_stall_pct <= 50;
        repeat (RANDOM_PER_PHASE) send_random_access();

        // Hold the output off while the sender streams, so the block backs up
        // and stalls its input.
        sender_idle_pct    = 0;
        hold_off_requests <= hold_off_requests + 1;
        repeat (BURST_ITEMS) send_random_access();

        // Half-idle sender, mostly ready receiver.
        sender_idle_pct     = 50;
        receiver_stall_pct <= 16;
        repeat (RANDOM_PER_PHASE) send_random_access();

        // Drop valid and drain every outstanding result before going on.
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);

        // No idling on either side.
        sender_idle_pct     = 0;
        receiver_stall_pct <= 0;
        repeat (RANDOM_PER_PHASE) send_random_access();

        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        // Allow for the result register before the verdict.
        repeat (4) @(negedge clk);

        $display("Covered %0d accesses: directed corners, random traffic in three idling mixes,",
                 items_sent);
        $display("an output hold-off and a full drain; %0d results compared, %0d mismatches.",
                 checked_results, mismatch_count);
        if (mismatch_count == 0)
            $display("segmented_big_endian_memory regression: pass");
        else
            $display("segmented_big_endian_memory regression: fail");
        $finish;
    end

    // Watchdog: far beyond the clearing pass plus the slowest legal traffic.
    initial
    begin
        #5_000_000;
        $display("segmented_big_endian_memory regression: fail");
        $finish;
    end

endmodule
